/* src/process_table_scheduler_defines.svh */
// assertion macros for the process table scheduler
`ifndef PROCESS_TABLE_SCHEDULER_DEFINES_SVH
`define PROCESS_TABLE_SCHEDULER_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define PTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/pts_pkg.sv */
// shared types and constants of the process table scheduler
package pts_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNTS_W    = $clog2(SLOTS + 1);
  localparam int PID_W     = 16;
  localparam int CNT_W     = 32;
  localparam int SHARE_W   = 17;
  localparam int AVAIL_W   = SHARE_W + 1;
  localparam int RATE_W    = 8;
  localparam int PROD_W    = CNT_W + SHARE_W;
  localparam int WIDE_W    = CNT_W + PROD_W;
  localparam int RQ_T_W    = 28;
  localparam int RQ_W      = 36;
  localparam int DIV_N     = 24;
  localparam int DIV_D     = 8;
  localparam int DIV_CW    = $clog2(DIV_N);

  localparam logic [SHARE_W-1:0] ONE_SHARE = SHARE_W'(65536);
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [RQ_T_W-1:0]  RQ_MILLI  = RQ_T_W'(1000);
  localparam logic [RQ_W-1:0]    RQ_SCALE  = RQ_W'(65536000);

  localparam logic [2:0] POL_LOWEST  = 3'd0;
  localparam logic [2:0] POL_OLDEST  = 3'd1;
  localparam logic [2:0] POL_HIGHEST = 3'd2;
  localparam logic [2:0] POL_RROBIN  = 3'd3;
  localparam logic [2:0] POL_PROP    = 3'd4;

  typedef enum logic [1:0] {
    CMD_START, CMD_END, CMD_SCHED, CMD_RATE
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK, ST_FULL, ST_NOT_FOUND, ST_BAD_RATE, ST_NO_SHARE
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_FD_SEL, S_FD_GET, S_RQ_M1, S_RQ_M2, S_RQ_CMP, S_DIV,
    S_RQ_WR, S_SPLIT, S_SP_WR, S_PICK_RD, S_OL_SEL, S_OL_GET, S_PR_SEL,
    S_PR_GET, S_PR_L0, S_PR_L1, S_PR_LS, S_PR_R0, S_PR_R1, S_PR_RS, S_PR_END,
    S_PR_BUMP
  } state_t;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [CNT_W-1:0] arrival;
    logic [CNT_W-1:0] alive;
    logic [CNT_W-1:0] run;
  } slot_t;

endpackage

/* src/pts_ram.sv */
// generic single write port ram with registered read
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/process_table_scheduler.sv */
// process table scheduler top level: sequencer around the slot rams
//
//   channel   signals                                   transfer when
//   config    policy_we, policy_data                    policy_we high
//   command   start, busy, command, pid, rate_num/den   start high, busy low
//   result    done, status, chosen_pid                  done high
//
// one command at a time; busy stays high until the result strobe is set up
// start: writes the new slot, then the share split; end and rate request walk
// the table slot by slot; a rate request then checks the available share, runs
// the bit-serial divider and writes the grant before the split; the split runs
// its 24 divider steps, then writes the unreserved slots in turn; proportional
// scheduling compares cross products slot by slot, then bumps the chosen run
// count; the other policies read one slot, oldest arrival walks the table
// synchronous reset empties the table; the result is held for one cycle only
`include "process_table_scheduler_defines.svh"

module process_table_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        policy_we,
  input  logic [2:0]  policy_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [15:0] pid,
  input  logic [7:0]  rate_num,
  input  logic [7:0]  rate_den,
  output logic        done,
  output logic [2:0]  status,
  output logic [15:0] chosen_pid
);

  localparam int SW  = pts_pkg::SLOT_W;
  localparam int MW  = $bits(pts_pkg::slot_t);
  localparam int CW  = pts_pkg::CNT_W;
  localparam int HW  = pts_pkg::SHARE_W;
  localparam int PW  = pts_pkg::PROD_W;
  localparam int WW  = pts_pkg::WIDE_W;
  localparam int AW  = pts_pkg::AVAIL_W;
  localparam logic [SW-1:0] LAST = SW'(pts_pkg::SLOTS - 1);

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == pts_pkg::CNT_MAX) ? v : v + 1'b1;
  endfunction

  // control state
  pts_pkg::state_t state, state_next;
  logic [2:0]  policy;
  logic        done_next;
  logic [2:0]  status_next;
  logic [15:0] chosen_next;
  logic [pts_pkg::SLOTS-1:0] slot_valid, slot_valid_next;
  logic [pts_pkg::SLOTS-1:0] slot_reserved, slot_reserved_next;
  logic [SW-1:0] rr_pointer, rr_pointer_next;
  logic [CW-1:0] arrival_counter, arrival_counter_next;
  logic [HW-1:0] free_share, free_share_next;

  // payload
  pts_pkg::cmd_t cmd;
  logic [15:0] req_pid;
  logic [7:0]  req_m, req_n;
  logic [SW-1:0] idx, idx_next;
  logic        best_ok, best_ok_next;
  logic [SW-1:0] best_idx, best_idx_next;
  logic [CW-1:0] best_run, best_run_next;
  logic [PW-1:0] best_p, best_p_next;
  logic [CW-1:0] best_arr, best_arr_next;
  logic [15:0] best_pid, best_pid_next;
  logic [CW-1:0] cur_run, cur_run_next;
  logic [PW-1:0] cur_p, cur_p_next;
  logic [2*CW-1:0] prod_a, prod_a_next;
  logic [PW-1:0] prod_b, prod_b_next;
  logic [WW-1:0] lhs, lhs_next;
  logic [AW-1:0] avail, avail_next;
  logic [pts_pkg::RQ_T_W-1:0] rq_t, rq_t_next;
  logic [pts_pkg::RQ_W-1:0] rq_lhs, rq_lhs_next, rq_rhs, rq_rhs_next;
  logic [pts_pkg::DIV_D-1:0] div_rem, div_rem_next, div_den, div_den_next;
  logic [pts_pkg::DIV_N-1:0] div_quo, div_quo_next;
  logic [pts_pkg::DIV_CW-1:0] div_cnt, div_cnt_next;

  // ram ports
  logic          main_we, share_we, rd_en;
  logic [SW-1:0] main_waddr, share_waddr, rd_addr;
  logic [MW-1:0] main_wdata, main_rdata;
  logic [HW-1:0] share_wdata, share_rd;
  pts_pkg::slot_t rd, wr;

  // encoders over the valid bits
  logic          free_any, low_any, rr_any;
  logic [SW-1:0] free_idx, low_idx, high_idx, rr_idx;
  logic [pts_pkg::SLOTS-1:0] mask;
  logic [pts_pkg::CNTS_W-1:0] split_cnt;

  // datapath helpers
  logic [CW-1:0] alive_inc;
  logic [PW-1:0] p_c;
  logic [WW-1:0] rhs_c;
  logic [AW-1:0] avail_c, fsum;
  logic [pts_pkg::DIV_D:0] rem_sh, rem_sub;
  logic          div_ge;
  logic [HW-1:0] quo_s;

  pts_ram #(.WIDTH(MW), .DEPTH(pts_pkg::SLOTS)) u_main_ram (
    .clk     (clk),
    .wr_en   (main_we),
    .wr_addr (main_waddr),
    .wr_data (main_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (main_rdata)
  );

  pts_ram #(.WIDTH(HW), .DEPTH(pts_pkg::SLOTS)) u_share_ram (
    .clk     (clk),
    .wr_en   (share_we),
    .wr_addr (share_waddr),
    .wr_data (share_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (share_rd)
  );

  assign rd = pts_pkg::slot_t'(main_rdata);
  assign main_wdata = MW'(wr);
  assign busy = (state != pts_pkg::S_IDLE);

  always_comb begin
    int j;
    free_any = 1'b0;
    low_any  = 1'b0;
    rr_any   = 1'b0;
    free_idx = '0;
    low_idx  = '0;
    high_idx = '0;
    rr_idx   = '0;
    for (int i = pts_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end else begin
        low_any = 1'b1;
        low_idx = SW'(i);
      end
    end
    for (int i = 0; i < pts_pkg::SLOTS; i++) begin
      if (slot_valid[i]) begin
        high_idx = SW'(i);
      end
    end
    // nearest valid slot after the pointer, wrapping round
    for (int k = pts_pkg::SLOTS; k >= 1; k--) begin
      j = int'(rr_pointer) + k;
      if (j >= pts_pkg::SLOTS) begin
        j = j - pts_pkg::SLOTS;
      end
      if (slot_valid[SW'(j)]) begin
        rr_any = 1'b1;
        rr_idx = SW'(j);
      end
    end
    mask      = slot_valid & ~slot_reserved;
    split_cnt = pts_pkg::CNTS_W'($countones(mask));
  end

  always_comb begin
    alive_inc = sat_inc(rd.alive);
    p_c       = PW'(alive_inc) * PW'(share_rd);
    rhs_c     = WW'(prod_a) + {prod_b, {CW{1'b0}}};
    avail_c   = {1'b0, free_share} + (slot_reserved[idx] ? {1'b0, share_rd} : '0);
    fsum      = {1'b0, free_share} + {1'b0, share_rd};
    rem_sh    = {div_rem, div_quo[pts_pkg::DIV_N-1]};
    div_ge    = rem_sh >= {1'b0, div_den};
    rem_sub   = div_ge ? rem_sh - {1'b0, div_den} : rem_sh;
    quo_s     = div_quo[HW-1:0];
  end

  always_comb begin
    state_next           = state;
    done_next            = 1'b0;
    status_next          = pts_pkg::ST_OK;
    chosen_next          = '0;
    slot_valid_next      = slot_valid;
    slot_reserved_next   = slot_reserved;
    rr_pointer_next      = rr_pointer;
    arrival_counter_next = arrival_counter;
    free_share_next      = free_share;
    idx_next             = idx;
    best_ok_next         = best_ok;
    best_idx_next        = best_idx;
    best_run_next        = best_run;
    best_p_next          = best_p;
    best_arr_next        = best_arr;
    best_pid_next        = best_pid;
    cur_run_next         = cur_run;
    cur_p_next           = cur_p;
    prod_a_next          = prod_a;
    prod_b_next          = prod_b;
    lhs_next             = lhs;
    avail_next           = avail;
    rq_t_next            = rq_t;
    rq_lhs_next          = rq_lhs;
    rq_rhs_next          = rq_rhs;
    div_rem_next         = div_rem;
    div_den_next         = div_den;
    div_quo_next         = div_quo;
    div_cnt_next         = div_cnt;
    main_we              = 1'b0;
    main_waddr           = idx;
    wr                   = rd;
    share_we             = 1'b0;
    share_waddr          = idx;
    share_wdata          = quo_s;
    rd_en                = 1'b0;
    rd_addr              = idx;

    unique case (state)
      pts_pkg::S_IDLE: begin
        if (start) begin
          state_next = pts_pkg::S_DECODE;
        end
      end

      pts_pkg::S_DECODE: begin
        idx_next     = '0;
        best_ok_next = 1'b0;
        unique case (cmd)
          pts_pkg::CMD_START: begin
            if (!free_any) begin
              state_next  = pts_pkg::S_IDLE;
              done_next   = 1'b1;
              status_next = pts_pkg::ST_FULL;
            end else begin
              main_we    = 1'b1;
              main_waddr = free_idx;
              wr         = '{pid: req_pid, arrival: arrival_counter, alive: '0, run: '0};
              share_we    = 1'b1;
              share_waddr = free_idx;
              share_wdata = '0;
              idx_next    = free_idx;
              slot_valid_next[free_idx]    = 1'b1;
              slot_reserved_next[free_idx] = 1'b0;
              arrival_counter_next = sat_inc(arrival_counter);
              state_next = pts_pkg::S_SPLIT;
            end
          end
          pts_pkg::CMD_END: begin
            state_next = pts_pkg::S_FD_SEL;
          end
          pts_pkg::CMD_RATE: begin
            if (req_m == '0 || req_n == '0 || req_m > req_n) begin
              state_next  = pts_pkg::S_IDLE;
              done_next   = 1'b1;
              status_next = pts_pkg::ST_BAD_RATE;
            end else begin
              state_next = pts_pkg::S_FD_SEL;
            end
          end
          pts_pkg::CMD_SCHED: begin
            unique case (policy)
              pts_pkg::POL_LOWEST, pts_pkg::POL_HIGHEST: begin
                rd_addr = (policy == pts_pkg::POL_LOWEST) ? low_idx : high_idx;
                if (low_any) begin
                  rd_en      = 1'b1;
                  state_next = pts_pkg::S_PICK_RD;
                end else begin
                  state_next = pts_pkg::S_IDLE;
                  done_next  = 1'b1;
                end
              end
              pts_pkg::POL_RROBIN: begin
                rd_addr = rr_idx;
                if (rr_any) begin
                  rd_en           = 1'b1;
                  rr_pointer_next = rr_idx;
                  state_next      = pts_pkg::S_PICK_RD;
                end else begin
                  state_next = pts_pkg::S_IDLE;
                  done_next  = 1'b1;
                end
              end
              pts_pkg::POL_OLDEST: begin
                state_next = pts_pkg::S_OL_SEL;
              end
              pts_pkg::POL_PROP: begin
                state_next = pts_pkg::S_PR_SEL;
              end
              default: begin
                state_next = pts_pkg::S_IDLE;
                done_next  = 1'b1;
              end
            endcase
          end
        endcase
      end

      pts_pkg::S_PICK_RD: begin
        state_next  = pts_pkg::S_IDLE;
        done_next   = 1'b1;
        chosen_next = rd.pid;
      end

      // lowest valid slot holding the pid
      pts_pkg::S_FD_SEL: begin
        if (slot_valid[idx]) begin
          rd_en      = 1'b1;
          state_next = pts_pkg::S_FD_GET;
        end else if (idx == LAST) begin
          state_next  = pts_pkg::S_IDLE;
          done_next   = 1'b1;
          status_next = pts_pkg::ST_NOT_FOUND;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      pts_pkg::S_FD_GET: begin
        if (rd.pid == req_pid) begin
          if (cmd == pts_pkg::CMD_END) begin
            slot_valid_next[idx]    = 1'b0;
            slot_reserved_next[idx] = 1'b0;
            if (slot_reserved[idx]) begin
              free_share_next = (fsum > {1'b0, pts_pkg::ONE_SHARE}) ? pts_pkg::ONE_SHARE
                                                                   : fsum[HW-1:0];
            end
            state_next = pts_pkg::S_SPLIT;
          end else begin
            state_next = pts_pkg::S_RQ_M1;
          end
        end else if (idx == LAST) begin
          state_next  = pts_pkg::S_IDLE;
          done_next   = 1'b1;
          status_next = pts_pkg::ST_NOT_FOUND;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = pts_pkg::S_FD_SEL;
        end
      end

      // n*(1000*avail + one) against one*1000*m
      pts_pkg::S_RQ_M1: begin
        avail_next  = avail_c;
        rq_t_next   = pts_pkg::RQ_T_W'(avail_c) * pts_pkg::RQ_MILLI
                      + pts_pkg::RQ_T_W'(pts_pkg::ONE_SHARE);
        rq_rhs_next = pts_pkg::RQ_W'(req_m) * pts_pkg::RQ_SCALE;
        state_next  = pts_pkg::S_RQ_M2;
      end

      pts_pkg::S_RQ_M2: begin
        rq_lhs_next = pts_pkg::RQ_W'(req_n) * pts_pkg::RQ_W'(rq_t);
        state_next  = pts_pkg::S_RQ_CMP;
      end

      pts_pkg::S_RQ_CMP: begin
        if (rq_lhs < rq_rhs) begin
          state_next  = pts_pkg::S_IDLE;
          done_next   = 1'b1;
          status_next = pts_pkg::ST_NO_SHARE;
        end else begin
          // m * one + n / 2, rounded quotient of n
          div_quo_next = {req_m, 9'b0, req_n[7:1]};
          div_den_next = req_n;
          div_rem_next = '0;
          div_cnt_next = '0;
          state_next   = pts_pkg::S_DIV;
        end
      end

      pts_pkg::S_DIV: begin
        div_rem_next = rem_sub[pts_pkg::DIV_D-1:0];
        div_quo_next = {div_quo[pts_pkg::DIV_N-2:0], div_ge};
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == pts_pkg::DIV_CW'(pts_pkg::DIV_N - 1)) begin
          if (cmd == pts_pkg::CMD_RATE && !best_ok) begin
            state_next = pts_pkg::S_RQ_WR;
          end else begin
            idx_next   = '0;
            state_next = pts_pkg::S_SP_WR;
          end
        end
      end

      pts_pkg::S_RQ_WR: begin
        share_we    = 1'b1;
        share_wdata = quo_s;
        slot_reserved_next[idx] = 1'b1;
        free_share_next = (avail > {1'b0, quo_s}) ? HW'(avail - {1'b0, quo_s}) : '0;
        state_next = pts_pkg::S_SPLIT;
      end

      pts_pkg::S_SPLIT: begin
        // best_ok marks the divider as busy with the split
        best_ok_next = 1'b1;
        if (split_cnt == '0) begin
          state_next = pts_pkg::S_IDLE;
          done_next  = 1'b1;
        end else begin
          div_quo_next = pts_pkg::DIV_N'(free_share);
          div_den_next = pts_pkg::DIV_D'(split_cnt);
          div_rem_next = '0;
          div_cnt_next = '0;
          state_next   = pts_pkg::S_DIV;
        end
      end

      pts_pkg::S_SP_WR: begin
        share_we    = mask[idx];
        share_wdata = quo_s;
        if (idx == LAST) begin
          state_next = pts_pkg::S_IDLE;
          done_next  = 1'b1;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      pts_pkg::S_OL_SEL: begin
        if (slot_valid[idx]) begin
          rd_en      = 1'b1;
          state_next = pts_pkg::S_OL_GET;
        end else if (idx == LAST) begin
          state_next  = pts_pkg::S_IDLE;
          done_next   = 1'b1;
          chosen_next = best_ok ? best_pid : '0;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      pts_pkg::S_OL_GET: begin
        if (!best_ok || rd.arrival < best_arr) begin
          best_ok_next  = 1'b1;
          best_arr_next = rd.arrival;
          best_pid_next = rd.pid;
        end
        if (idx == LAST) begin
          state_next  = pts_pkg::S_IDLE;
          done_next   = 1'b1;
          chosen_next = (!best_ok || rd.arrival < best_arr) ? rd.pid : best_pid;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = pts_pkg::S_OL_SEL;
        end
      end

      pts_pkg::S_PR_SEL: begin
        if (slot_valid[idx]) begin
          rd_en      = 1'b1;
          state_next = pts_pkg::S_PR_GET;
        end else if (idx == LAST) begin
          state_next = pts_pkg::S_PR_END;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      pts_pkg::S_PR_GET: begin
        main_we = 1'b1;
        wr      = '{pid: rd.pid, arrival: rd.arrival, alive: alive_inc, run: rd.run};
        cur_run_next = rd.run;
        cur_p_next   = p_c;
        if (share_rd != '0 && best_ok) begin
          state_next = pts_pkg::S_PR_L0;
        end else begin
          if (share_rd != '0) begin
            best_ok_next  = 1'b1;
            best_idx_next = idx;
            best_run_next = rd.run;
            best_p_next   = p_c;
          end
          if (idx == LAST) begin
            state_next = pts_pkg::S_PR_END;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = pts_pkg::S_PR_SEL;
          end
        end
      end

      // run_i * p_best and run_best * p_i in 32 bit partial products
      pts_pkg::S_PR_L0: begin
        prod_a_next = (2 * CW)'(cur_run) * (2 * CW)'(best_p[CW-1:0]);
        state_next  = pts_pkg::S_PR_L1;
      end

      pts_pkg::S_PR_L1: begin
        prod_b_next = PW'(cur_run) * PW'(best_p[PW-1:CW]);
        state_next  = pts_pkg::S_PR_LS;
      end

      pts_pkg::S_PR_LS: begin
        lhs_next   = rhs_c;
        state_next = pts_pkg::S_PR_R0;
      end

      pts_pkg::S_PR_R0: begin
        prod_a_next = (2 * CW)'(best_run) * (2 * CW)'(cur_p[CW-1:0]);
        state_next  = pts_pkg::S_PR_R1;
      end

      pts_pkg::S_PR_R1: begin
        prod_b_next = PW'(best_run) * PW'(cur_p[PW-1:CW]);
        state_next  = pts_pkg::S_PR_RS;
      end

      pts_pkg::S_PR_RS: begin
        if (lhs < rhs_c) begin
          best_idx_next = idx;
          best_run_next = cur_run;
          best_p_next   = cur_p;
        end
        if (idx == LAST) begin
          state_next = pts_pkg::S_PR_END;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = pts_pkg::S_PR_SEL;
        end
      end

      pts_pkg::S_PR_END: begin
        rd_addr = best_idx;
        if (best_ok) begin
          rd_en      = 1'b1;
          state_next = pts_pkg::S_PR_BUMP;
        end else begin
          state_next = pts_pkg::S_IDLE;
          done_next  = 1'b1;
        end
      end

      pts_pkg::S_PR_BUMP: begin
        main_we     = 1'b1;
        main_waddr  = best_idx;
        wr          = '{pid: rd.pid, arrival: rd.arrival, alive: rd.alive,
                        run: sat_inc(rd.run)};
        state_next  = pts_pkg::S_IDLE;
        done_next   = 1'b1;
        chosen_next = rd.pid;
      end

      default: begin
        state_next = pts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= pts_pkg::S_IDLE;
      policy          <= pts_pkg::POL_PROP;
      done            <= 1'b0;
      slot_valid      <= '0;
      rr_pointer      <= LAST;
      arrival_counter <= '0;
      free_share      <= pts_pkg::ONE_SHARE;
    end else begin
      state           <= state_next;
      done            <= done_next;
      slot_valid      <= slot_valid_next;
      rr_pointer      <= rr_pointer_next;
      arrival_counter <= arrival_counter_next;
      free_share      <= free_share_next;
      if (policy_we) begin
        policy <= policy_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd     <= pts_pkg::cmd_t'(command);
      req_pid <= pid;
      req_m   <= rate_num;
      req_n   <= rate_den;
    end
    status        <= status_next;
    chosen_pid    <= chosen_next;
    slot_reserved <= slot_reserved_next;
    idx           <= idx_next;
    best_ok       <= best_ok_next;
    best_idx      <= best_idx_next;
    best_run      <= best_run_next;
    best_p        <= best_p_next;
    best_arr      <= best_arr_next;
    best_pid      <= best_pid_next;
    cur_run       <= cur_run_next;
    cur_p         <= cur_p_next;
    prod_a        <= prod_a_next;
    prod_b        <= prod_b_next;
    lhs           <= lhs_next;
    avail         <= avail_next;
    rq_t          <= rq_t_next;
    rq_lhs        <= rq_lhs_next;
    rq_rhs        <= rq_rhs_next;
    div_rem       <= div_rem_next;
    div_den       <= div_den_next;
    div_quo       <= div_quo_next;
    div_cnt       <= div_cnt_next;
  end

  `PTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
  `PTS_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for two cycles")
  `PTS_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result without a command")
  `PTS_ASSERT_NOW(a_chosen_ok, done && chosen_pid != 16'd0, status == pts_pkg::ST_OK,
                  "chosen pid given with a failure status")

endmodule

/* tb/sv/pts_checker.sv */
// checker for the process table scheduler: predicts every result and compares it
`timescale 1ns / 1ps

module pts_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        policy_we,
  input  logic [2:0]  policy_data,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  command,
  input  logic [15:0] pid,
  input  logic [7:0]  rate_num,
  input  logic [7:0]  rate_den,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [15:0] chosen_pid,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    pts_pkg::status_t st;
    logic [15:0]      chosen;
  } answer_t;

  answer_t answer_q[$];

  logic                        tbl_valid[pts_pkg::SLOTS];
  logic [pts_pkg::PID_W-1:0]   tbl_pid[pts_pkg::SLOTS];
  logic [pts_pkg::CNT_W-1:0]   tbl_arrival[pts_pkg::SLOTS];
  logic [pts_pkg::CNT_W-1:0]   tbl_alive[pts_pkg::SLOTS];
  logic [pts_pkg::CNT_W-1:0]   tbl_run[pts_pkg::SLOTS];
  logic [pts_pkg::SHARE_W-1:0] tbl_share[pts_pkg::SLOTS];
  logic                        tbl_reserved[pts_pkg::SLOTS];
  logic [pts_pkg::SLOT_W-1:0]  rr_ptr;
  logic [pts_pkg::CNT_W-1:0]   arrivals;
  logic [pts_pkg::SHARE_W-1:0] free_sh;
  logic [2:0]                  cur_policy;

  function automatic logic [pts_pkg::CNT_W-1:0] sat_inc(logic [pts_pkg::CNT_W-1:0] v);
    return (v == pts_pkg::CNT_MAX) ? v : v + 1;
  endfunction

  // exact run/(alive*share) compare by cross multiplication
  function automatic bit ratio_less(int a, int b);
    logic [95:0] lhs, rhs;
    lhs = 96'(tbl_run[a]) * 96'(tbl_alive[b]) * 96'(tbl_share[b]);
    rhs = 96'(tbl_run[b]) * 96'(tbl_alive[a]) * 96'(tbl_share[a]);
    return lhs < rhs;
  endfunction

  function automatic void split_free_share();
    int cnt;
    logic [pts_pkg::SHARE_W-1:0] each;
    cnt = 0;
    for (int i = 0; i < pts_pkg::SLOTS; i++) if (tbl_valid[i] && !tbl_reserved[i]) cnt++;
    if (cnt == 0) return;
    each = pts_pkg::SHARE_W'(free_sh / cnt);
    for (int i = 0; i < pts_pkg::SLOTS; i++)
      if (tbl_valid[i] && !tbl_reserved[i]) tbl_share[i] = each;
  endfunction

  function automatic int lookup_pid(logic [15:0] p);
    for (int i = 0; i < pts_pkg::SLOTS; i++) if (tbl_valid[i] && tbl_pid[i] == p) return i;
    return -1;
  endfunction

  function automatic logic [15:0] pick_next();
    int best;
    int idx;
    best = -1;
    case (cur_policy)
      pts_pkg::POL_LOWEST: begin
        for (int i = 0; i < pts_pkg::SLOTS; i++) if (tbl_valid[i]) return tbl_pid[i];
      end
      pts_pkg::POL_OLDEST: begin
        for (int i = 0; i < pts_pkg::SLOTS; i++)
          if (tbl_valid[i] && (best < 0 || tbl_arrival[i] < tbl_arrival[best])) best = i;
        if (best >= 0) return tbl_pid[best];
      end
      pts_pkg::POL_HIGHEST: begin
        for (int i = pts_pkg::SLOTS - 1; i >= 0; i--) if (tbl_valid[i]) return tbl_pid[i];
      end
      pts_pkg::POL_RROBIN: begin
        for (int k = 1; k <= pts_pkg::SLOTS; k++) begin
          idx = (int'(rr_ptr) + k) % pts_pkg::SLOTS;
          if (tbl_valid[idx]) begin
            rr_ptr = pts_pkg::SLOT_W'(idx);
            return tbl_pid[idx];
          end
        end
      end
      pts_pkg::POL_PROP: begin
        for (int i = 0; i < pts_pkg::SLOTS; i++) begin
          if (tbl_valid[i]) begin
            tbl_alive[i] = sat_inc(tbl_alive[i]);
            // a zero share is never picked
            if (tbl_share[i] != 0 && (best < 0 || ratio_less(i, best))) best = i;
          end
        end
        if (best >= 0) begin
          tbl_run[best] = sat_inc(tbl_run[best]);
          return tbl_pid[best];
        end
      end
      default: ;
    endcase
    return '0;
  endfunction

  function automatic answer_t predict_command(pts_pkg::cmd_t c, logic [15:0] p,
                                              logic [7:0] m, logic [7:0] n);
    answer_t a;
    int i;
    logic [63:0] avail, granted, lhs, rhs;
    a.st = pts_pkg::ST_OK;
    a.chosen = '0;
    case (c)
      pts_pkg::CMD_START: begin
        i = -1;
        for (int s = pts_pkg::SLOTS - 1; s >= 0; s--) if (!tbl_valid[s]) i = s;
        if (i < 0) a.st = pts_pkg::ST_FULL;
        else begin
          tbl_valid[i] = 1'b1;
          tbl_pid[i] = p;
          tbl_arrival[i] = arrivals;
          arrivals = sat_inc(arrivals);
          tbl_alive[i] = '0;
          tbl_run[i] = '0;
          tbl_share[i] = '0;
          tbl_reserved[i] = 1'b0;
          split_free_share();
        end
      end
      pts_pkg::CMD_END: begin
        i = lookup_pid(p);
        if (i < 0) a.st = pts_pkg::ST_NOT_FOUND;
        else begin
          tbl_valid[i] = 1'b0;
          // a reserved share goes back to the pool, capped at one cpu
          if (tbl_reserved[i]) begin
            avail = 64'(free_sh) + 64'(tbl_share[i]);
            free_sh = (avail > 64'(pts_pkg::ONE_SHARE)) ? pts_pkg::ONE_SHARE
                                                        : pts_pkg::SHARE_W'(avail);
          end
          tbl_reserved[i] = 1'b0;
          split_free_share();
        end
      end
      pts_pkg::CMD_SCHED: a.chosen = pick_next();
      default: begin
        i = lookup_pid(p);
        if (m == 0 || n == 0 || m > n) a.st = pts_pkg::ST_BAD_RATE;
        else if (i < 0) a.st = pts_pkg::ST_NOT_FOUND;
        else begin
          avail = 64'(free_sh) + (tbl_reserved[i] ? 64'(tbl_share[i]) : 64'd0);
          lhs = 64'(n) * (64'd1000 * avail + 64'd65536);
          rhs = 64'd65536000 * 64'(m);
          if (lhs < rhs) a.st = pts_pkg::ST_NO_SHARE;
          else begin
            granted = (64'(m) * 64'd65536 + 64'(n / 2)) / 64'(n);
            tbl_share[i] = pts_pkg::SHARE_W'(granted);
            tbl_reserved[i] = 1'b1;
            free_sh = (avail > granted) ? pts_pkg::SHARE_W'(avail - granted) : '0;
            split_free_share();
          end
        end
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      for (int i = 0; i < pts_pkg::SLOTS; i++) begin
        tbl_valid[i] = 1'b0;
        tbl_reserved[i] = 1'b0;
      end
      rr_ptr = pts_pkg::SLOT_W'(pts_pkg::SLOTS - 1);
      arrivals = '0;
      free_sh = pts_pkg::ONE_SHARE;
      cur_policy = pts_pkg::POL_PROP;
      answer_q.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (answer_q.size() == 0) begin
          $error("result with nothing expected: status %0d chosen_pid %0d", status, chosen_pid);
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, status);
            fail_count++;
          end
          if (chosen_pid !== want.chosen) begin
            $error("chosen_pid: expected %0d, actual %0d", want.chosen, chosen_pid);
            fail_count++;
          end
        end
      end
      if (policy_we) cur_policy = policy_data;
      if (start && !busy)
        answer_q.push_back(predict_command(pts_pkg::cmd_t'(command), pid, rate_num,
                                           rate_den));
    end
    outstanding = answer_q.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// top of the process table scheduler testbench: stimulus, policy phases and verdict
`timescale 1ns / 1ps

module tb_top;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        policy_we = 1'b0;
  logic [2:0]  policy_data = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = '0;
  logic [15:0] pid = '0;
  logic [7:0]  rate_num = '0;
  logic [7:0]  rate_den = '0;
  logic        done;
  logic [2:0]  status;
  logic [15:0] chosen_pid;
  int          fail_count;
  int          outstanding;
  int          cycles = 0;
  bit          allow_gaps = 1'b1;

  localparam int CYCLE_LIMIT = 1000000;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  process_table_scheduler u_dut (
    .clk(clk), .rst(rst), .policy_we(policy_we), .policy_data(policy_data),
    .start(start), .busy(busy), .command(command), .pid(pid),
    .rate_num(rate_num), .rate_den(rate_den), .done(done), .status(status),
    .chosen_pid(chosen_pid)
  );

  pts_checker u_checker (
    .clk(clk), .rst(rst), .policy_we(policy_we), .policy_data(policy_data),
    .start(start), .busy(busy), .command(command), .pid(pid),
    .rate_num(rate_num), .rate_den(rate_den), .done(done), .status(status),
    .chosen_pid(chosen_pid), .fail_count(fail_count), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one command transfer; start stays high afterwards unless a gap follows
  task automatic issue(pts_pkg::cmd_t c, logic [15:0] p, logic [7:0] m, logic [7:0] n);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    command <= c;
    pid <= p;
    rate_num <= m;
    rate_den <= n;
    do @(posedge clk); while (busy);
  endtask

  task automatic set_policy(logic [2:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    policy_we <= 1'b1;
    policy_data <= value;
    @(posedge clk);
    policy_we <= 1'b0;
  endtask

  function automatic logic [15:0] any_pid();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(1, 14));
  endfunction

  task automatic random_item();
    int sel;
    logic [7:0] m, n;
    sel = $urandom_range(0, 99);
    n = 8'($urandom_range(1, 16));
    m = 8'($urandom_range(1, n));
    if (sel >= 80) begin
      case ($urandom_range(0, 4))
        0: m = 0;
        1: n = 0;
        2: begin n = 8'($urandom_range(1, 254)); m = 8'($urandom_range(n + 1, 255)); end
        3: begin n = 8'($urandom); m = 8'($urandom_range(1, n > 0 ? n : 1)); end
        default: begin m = 8'($urandom); n = 8'($urandom); end
      endcase
    end
    if (sel < 33) issue(pts_pkg::CMD_START, any_pid(), 8'($urandom), 8'($urandom));
    else if (sel < 53) issue(pts_pkg::CMD_END, any_pid(), 8'($urandom), 8'($urandom));
    else if (sel < 75) issue(pts_pkg::CMD_SCHED, 16'($urandom), 8'($urandom), 8'($urandom));
    else issue(pts_pkg::CMD_RATE, any_pid(), m, n);
  endtask

  initial begin
    logic [2:0] phase_policy[10] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd7, 3'd4, 3'd5, 3'd6,
                                     3'd3, 3'd4};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes, special cases under proportional share
    issue(pts_pkg::CMD_SCHED, 16'h0000, 8'h00, 8'h00);
    issue(pts_pkg::CMD_END, 16'hFFFF, 8'h00, 8'h00);
    issue(pts_pkg::CMD_RATE, 16'h0005, 8'd1, 8'd2);
    issue(pts_pkg::CMD_START, 16'h0000, 8'hFF, 8'hFF);
    issue(pts_pkg::CMD_START, 16'hFFFF, 8'h00, 8'h00);
    issue(pts_pkg::CMD_START, 16'hFFFF, 8'h00, 8'h00);
    issue(pts_pkg::CMD_RATE, 16'hFFFF, 8'd0, 8'd5);
    issue(pts_pkg::CMD_RATE, 16'hFFFF, 8'd5, 8'd0);
    issue(pts_pkg::CMD_RATE, 16'hFFFF, 8'd255, 8'd254);
    issue(pts_pkg::CMD_RATE, 16'h1234, 8'd1, 8'd4);
    // whole cpu to one entry leaves the rest with a zero share
    issue(pts_pkg::CMD_RATE, 16'h0000, 8'd255, 8'd255);
    issue(pts_pkg::CMD_SCHED, 16'h0000, 8'h00, 8'h00);
    issue(pts_pkg::CMD_SCHED, 16'h0000, 8'h00, 8'h00);
    issue(pts_pkg::CMD_RATE, 16'hFFFF, 8'd1, 8'd255);
    issue(pts_pkg::CMD_RATE, 16'h0000, 8'd1, 8'd3);
    issue(pts_pkg::CMD_RATE, 16'hFFFF, 8'd2, 8'd3);
    issue(pts_pkg::CMD_END, 16'h0000, 8'h00, 8'h00);
    for (int i = 0; i < 14; i++) issue(pts_pkg::CMD_START, 16'(16'h0100 + i), 8'h00, 8'h00);
    issue(pts_pkg::CMD_START, 16'h5A5A, 8'h00, 8'h00);
    issue(pts_pkg::CMD_SCHED, 16'h0000, 8'h00, 8'h00);
    issue(pts_pkg::CMD_END, 16'hFFFF, 8'h00, 8'h00);
    issue(pts_pkg::CMD_SCHED, 16'h0000, 8'h00, 8'h00);

    // random phases, one policy each; the last one runs without gaps
    for (int ph = 0; ph < 10; ph++) begin
      set_policy(phase_policy[ph]);
      if (ph == 9) allow_gaps = 1'b0;
      for (int k = 0; k < 85; k++) random_item();
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
